FILE: design/lep_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lep_pkg
// Shared types, register indexes and constants for the line edge PID
// steering block.
// ============================================================================
package lep_pkg;

    localparam int LINE_PIXELS_DEF = 128;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int PIX_W    = 10;
    localparam int DIFF_W   = PIX_W + 1;
    localparam int ERR_W    = 7;
    localparam int CMD_W    = 8;
    localparam int GAIN_W   = 16;
    localparam int UCFG_W   = 7;
    localparam int INTEG_W  = 32;
    localparam int DTERM_W  = 4;
    localparam int SUM_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST       = 16'sd256;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST       = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST       = 16'sd0;
    localparam logic [UCFG_W-1:0]        CENTER_INDEX_RST = 7'd64;
    localparam logic [UCFG_W-1:0]        SERVO_CENTER_RST = 7'd85;
    localparam logic [UCFG_W-1:0]        SERVO_LIMIT_RST  = 7'd30;
    localparam logic [CMD_W-1:0]         HELD_CMD_RST     = 8'd85;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P       = 3'd0,
        CFG_GAIN_D       = 3'd1,
        CFG_GAIN_I       = 3'd2,
        CFG_CENTER_INDEX = 3'd3,
        CFG_SERVO_CENTER = 3'd4,
        CFG_SERVO_LIMIT  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             line_end;
    } pixel_in_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] line_error;
        logic [CMD_W-1:0]        servo_cmd;
        logic                    in_range;
    } steer_out_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [GAIN_W-1:0] gain_i;
        logic [UCFG_W-1:0]        center_index;
        logic [UCFG_W-1:0]        servo_center;
        logic [UCFG_W-1:0]        servo_limit;
    } cfg_t;

    // (a - b) / 20 truncated toward zero, for a difference in -127..127.
    // Magnitude times 205 / 4096 is exact over that range.
    function automatic logic signed [DTERM_W-1:0] div20(input logic signed [7:0] v);
        logic [6:0]  mag;
        logic [14:0] prod;
        logic [2:0]  q;
        begin
            mag  = v[7] ? 7'(-v) : v[6:0];
            prod = 15'(mag) * 15'd205;
            q    = prod[14:12];
            div20 = v[7] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    endfunction

endpackage

FILE: design/lep_front.sv
`timescale 1ns / 1ps
// ============================================================================
// lep_front
// Pixel intake: running max/min of neighbor differences and the line error
// pushed to the queue at the end of each line.
// ============================================================================
module lep_front import lep_pkg::*; #(
    parameter int LINE_PIXELS = LINE_PIXELS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  pixel_in_t               s_data,
    input  logic [UCFG_W-1:0]       center_index,
    input  logic                    q_full,
    output logic                    q_push,
    output logic signed [ERR_W-1:0] q_err
);

    localparam int IDX_W = $clog2(LINE_PIXELS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_PIXELS - 1);

    logic [PIX_W-1:0]         prev_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [DIFF_W-1:0] max_reg, min_reg, max_next, min_next;
    logic [IDX_W-1:0]         max_idx_reg, min_idx_reg, max_idx_next, min_idx_next;

    logic signed [DIFF_W-1:0] diff;
    logic [IDX_W-1:0]         di;
    logic                     accept, last;
    logic [7:0]               idx_sum;
    logic [6:0]               mid;
    logic signed [8:0]        err_wide;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign last    = s_data.line_end || (idx_reg == LAST_IDX);
    assign q_push  = accept && last;

    assign diff = $signed({1'b0, prev_reg}) - $signed({1'b0, s_data.pixel_value});
    assign di   = idx_reg - 1'b1;

    always_comb begin
        max_next     = max_reg;
        min_next     = min_reg;
        max_idx_next = max_idx_reg;
        min_idx_next = min_idx_reg;
        if (idx_reg != '0) begin
            if (di == '0) begin
                max_next     = diff;
                min_next     = diff;
                max_idx_next = '0;
                min_idx_next = '0;
            end else begin
                if (diff > max_reg) begin
                    max_next     = diff;
                    max_idx_next = di;
                end
                if (diff < min_reg) begin
                    min_next     = diff;
                    min_idx_next = di;
                end
            end
        end
    end

    // midpoint of the max and min edge indices minus center, saturated to the signed ERR_W range
    assign idx_sum  = 8'(max_idx_next) + 8'(min_idx_next);
    assign mid      = idx_sum[7:1];
    assign err_wide = $signed({2'b00, mid}) - $signed({2'b00, center_index});

    always_comb begin
        if (err_wide > 9'sd63) begin
            q_err = 7'sd63;
        end else if (err_wide < -9'sd64) begin
            q_err = -7'sd64;
        end else begin
            q_err = err_wide[ERR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            idx_reg     <= '0;
            max_reg     <= '0;
            min_reg     <= '0;
            max_idx_reg <= '0;
            min_idx_reg <= '0;
        end else if (accept) begin
            if (last) begin
                prev_reg    <= '0;
                idx_reg     <= '0;
                max_reg     <= '0;
                min_reg     <= '0;
                max_idx_reg <= '0;
                min_idx_reg <= '0;
            end else begin
                prev_reg    <= s_data.pixel_value;
                idx_reg     <= idx_reg + 1'b1;
                max_reg     <= max_next;
                min_reg     <= min_next;
                max_idx_reg <= max_idx_next;
                min_idx_reg <= min_idx_next;
            end
        end
    end

endmodule

FILE: design/lep_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// lep_fifo
// Short queue of line errors between the pixel front end and the PID back
// end.
// ============================================================================
module lep_fifo import lep_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic signed [ERR_W-1:0] wdata,
    output logic                    full,
    input  logic                    pop,
    output logic                    rvalid,
    output logic signed [ERR_W-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic signed [ERR_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign rvalid  = (cnt_reg != '0);
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: design/lep_back.sv
`timescale 1ns / 1ps
// ============================================================================
// lep_back
// PID pipeline: integral and derivative update, gain products, sum, range
// test and servo command, with the result register on the output channel.
// ============================================================================
module lep_back import lep_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    q_valid,
    input  logic signed [ERR_W-1:0] q_err,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output steer_out_t              m_data
);

    localparam logic signed [INTEG_W:0] INT_MAX33 = 33'sh0_7FFF_FFFF;
    localparam logic signed [INTEG_W:0] INT_MIN33 = -33'sh0_8000_0000;

    // whole pipeline moves unless a finished result is waiting
    logic advance;

    // loop state across lines
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic [CMD_W-1:0]          held_reg;

    // stage A
    logic                      a_valid_reg;
    logic signed [ERR_W-1:0]   a_err_reg;
    logic signed [DTERM_W-1:0] a_dterm_reg;
    logic signed [INTEG_W-1:0] a_integ_reg;
    // stage B
    logic                      b_valid_reg;
    logic signed [ERR_W-1:0]   b_err_reg;
    logic signed [22:0]        b_p_reg;
    logic signed [19:0]        b_d_reg;
    logic signed [SUM_W-1:0]   b_i_reg;
    // stage C
    logic                      c_valid_reg;
    logic signed [ERR_W-1:0]   c_err_reg;
    logic signed [SUM_W-1:0]   c_sum_reg;
    // output
    logic                      m_valid_reg;
    steer_out_t                m_data_reg;

    logic signed [INTEG_W:0]   integ_wide;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [7:0]         ddiff;
    logic signed [22:0]        p_prod;
    logic signed [19:0]        d_prod;
    logic signed [SUM_W-1:0]   i_prod;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   lim;
    logic                      in_lim;
    logic [15:0]               adj;
    logic signed [15:0]        quot;
    logic signed [9:0]         cmd_wide;
    logic [CMD_W-1:0]          cmd_sat;
    logic [CMD_W-1:0]          held_next;

    assign advance = !m_valid_reg || m_ready;
    assign q_pop   = advance && q_valid;

    // stage A logic
    assign integ_wide = $signed({integ_reg[INTEG_W-1], integ_reg})
                      + $signed({{(INTEG_W + 1 - ERR_W){q_err[ERR_W-1]}}, q_err});
    always_comb begin
        if (integ_wide > INT_MAX33) begin
            integ_next = INT_MAX33[INTEG_W-1:0];
        end else if (integ_wide < INT_MIN33) begin
            integ_next = INT_MIN33[INTEG_W-1:0];
        end else begin
            integ_next = integ_wide[INTEG_W-1:0];
        end
    end
    assign ddiff = $signed({last_err_reg[ERR_W-1], last_err_reg})
                 - $signed({q_err[ERR_W-1], q_err});

    // stage B logic
    assign p_prod = $signed(a_err_reg) * $signed(cfg.gain_p);
    assign d_prod = $signed(a_dterm_reg) * $signed(cfg.gain_d);
    assign i_prod = $signed(a_integ_reg) * $signed(cfg.gain_i);

    // stage C logic
    assign sum_next = b_i_reg
                    + $signed({{(SUM_W - 23){b_p_reg[22]}}, b_p_reg})
                    + $signed({{(SUM_W - 20){b_d_reg[19]}}, b_d_reg});

    // output stage logic
    assign lim    = $signed({{(SUM_W - UCFG_W - 8){1'b0}}, cfg.servo_limit, 8'b0});
    assign in_lim = (c_sum_reg > -lim) && (c_sum_reg < lim);
    // inside the limit the sum fits 16 bits; bias negatives to truncate toward zero
    assign adj      = c_sum_reg[15:0] + (c_sum_reg[SUM_W-1] ? 16'd255 : 16'd0);
    assign quot     = $signed(adj) >>> 8;
    assign cmd_wide = $signed({3'b000, cfg.servo_center}) + $signed(quot[9:0]);
    always_comb begin
        if (cmd_wide < 10'sd0) begin
            cmd_sat = '0;
        end else if (cmd_wide > 10'sd255) begin
            cmd_sat = 8'd255;
        end else begin
            cmd_sat = cmd_wide[CMD_W-1:0];
        end
    end
    assign held_next = in_lim ? cmd_sat : held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            last_err_reg <= '0;
            held_reg     <= HELD_CMD_RST;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= q_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= c_valid_reg;
            if (q_valid) begin
                integ_reg    <= integ_next;
                last_err_reg <= q_err;
            end
            if (c_valid_reg) begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_err_reg   <= q_err;
            a_dterm_reg <= div20(ddiff);
            a_integ_reg <= integ_next;
            b_err_reg   <= a_err_reg;
            b_p_reg     <= p_prod;
            b_d_reg     <= d_prod;
            b_i_reg     <= i_prod;
            c_err_reg   <= b_err_reg;
            c_sum_reg   <= sum_next;
            m_data_reg.line_error <= c_err_reg;
            m_data_reg.servo_cmd  <= held_next;
            m_data_reg.in_range   <= in_lim;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: design/line_edge_pid_steering.sv
`timescale 1ns / 1ps
// ============================================================================
// line_edge_pid_steering
// Line-scan camera edge finder with PID servo steering.
// ============================================================================
// Throughput: one pixel beat per cycle while the queue has room; one result
// beat per cycle while m_ready is high. After the last pixel beat of a line,
// its result passes the queue, integral stage, product stage, sum stage and
// result register. The error queue decouples pixel intake from output stalls.
// Reset: config registers to defaults, line state and integral cleared,
// held servo command 85.
module line_edge_pid_steering import lep_pkg::*; #(
    parameter int LINE_PIXELS = LINE_PIXELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pixel_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output steer_out_t            m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t                    cfg_reg;
    logic                    q_full, q_push, q_pop, q_valid;
    logic signed [ERR_W-1:0] q_wdata, q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p       <= GAIN_P_RST;
            cfg_reg.gain_d       <= GAIN_D_RST;
            cfg_reg.gain_i       <= GAIN_I_RST;
            cfg_reg.center_index <= CENTER_INDEX_RST;
            cfg_reg.servo_center <= SERVO_CENTER_RST;
            cfg_reg.servo_limit  <= SERVO_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P:       cfg_reg.gain_p       <= cfg_wdata;
                CFG_GAIN_D:       cfg_reg.gain_d       <= cfg_wdata;
                CFG_GAIN_I:       cfg_reg.gain_i       <= cfg_wdata;
                CFG_CENTER_INDEX: cfg_reg.center_index <= cfg_wdata[UCFG_W-1:0];
                CFG_SERVO_CENTER: cfg_reg.servo_center <= cfg_wdata[UCFG_W-1:0];
                CFG_SERVO_LIMIT:  cfg_reg.servo_limit  <= cfg_wdata[UCFG_W-1:0];
                default: ;
            endcase
        end
    end

    lep_front #(
        .LINE_PIXELS (LINE_PIXELS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .center_index (cfg_reg.center_index),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_err        (q_wdata)
    );

    lep_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    lep_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_err   (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: test/line_edge_pid_steering_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// line_edge_pid_steering_tb
// Streams camera lines into the steering block and checks every result beat
// against an in-bench edge/PID predictor. The sequence is: directed short
// lines, full-length and overlong lines, saturation and limit corners, then
// random lines under changing gains, with three sender/receiver idle patterns.
// ============================================================================
module line_edge_pid_steering_tb;
    import lep_pkg::*;

    localparam int ROW_MAX        = 128;
    localparam int SETTLE_CYCLES  = 12;
    // No-accept cycles tolerated before the watchdog ends the run.
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {
        SHAPE_BAND,
        SHAPE_NOISE,
        SHAPE_FLAT,
        SHAPE_TOGGLE,
        SHAPE_SPIKE
    } shape_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pixel_in_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    steer_out_t            m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int snd_idle_pct = 11;
    int rcv_idle_pct = 69;
    int mismatches   = 0;
    int quiet_cycles = 0;

    steer_out_t steer_q[$];

    // predictor: register mirror
    int kp, kd, ki, ctr_idx, ctr_servo, servo_lim;
    // predictor: line and loop state
    int row_prev, row_idx;
    int peak_rise, peak_rise_idx, peak_fall, peak_fall_idx;
    int err_accum, prev_err, servo_hold;

    always #1 aclk = ~aclk;

    line_edge_pid_steering i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        steer_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (steer_q.size() == 0) begin
                $error("unexpected result beat: line_error %0d servo_cmd %0d in_range %0d",
                       m_data.line_error, m_data.servo_cmd, m_data.in_range);
                mismatches++;
            end else begin
                want = steer_q.pop_front();
                if (m_data.line_error !== want.line_error) begin
                    $error("line_error: expected %0d, got %0d",
                           want.line_error, m_data.line_error);
                    mismatches++;
                end
                if (m_data.servo_cmd !== want.servo_cmd) begin
                    $error("servo_cmd: expected %0d, got %0d",
                           want.servo_cmd, m_data.servo_cmd);
                    mismatches++;
                end
                if (m_data.in_range !== want.in_range) begin
                    $error("in_range: expected %0d, got %0d",
                           want.in_range, m_data.in_range);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic clear_row();
        row_prev      = 0;
        row_idx       = 0;
        peak_rise     = 0;
        peak_fall     = 0;
        peak_rise_idx = 0;
        peak_fall_idx = 0;
    endtask

    task automatic reset_model();
        kp         = 256;
        kd         = 0;
        ki         = 0;
        ctr_idx    = 64;
        ctr_servo  = 85;
        servo_lim  = 30;
        err_accum  = 0;
        prev_err   = 0;
        servo_hold = 85;
        clear_row();
    endtask

    // Edge tracking per pixel; at line end, error, integral, PID sum and command.
    task automatic track_pixel(input int pix, input bit le);
        int         d;
        int         err;
        int         dterm;
        longint     acc;
        longint     sum;
        longint     lim;
        longint     cmd;
        bit         row_done;
        bit         in_lim;
        steer_out_t beat;
        row_done = le || (row_idx >= ROW_MAX - 1);
        if (row_idx > 0) begin
            d = row_prev - pix;
            if (row_idx == 1) begin
                peak_rise     = d;
                peak_fall     = d;
                peak_rise_idx = 0;
                peak_fall_idx = 0;
            end else begin
                // strict compares keep the first index on ties
                if (d > peak_rise) begin
                    peak_rise     = d;
                    peak_rise_idx = row_idx - 1;
                end
                if (d < peak_fall) begin
                    peak_fall     = d;
                    peak_fall_idx = row_idx - 1;
                end
            end
        end
        row_prev = pix;
        if (!row_done) begin
            row_idx = row_idx + 1;
        end else begin
            err = (peak_rise_idx + peak_fall_idx) / 2 - ctr_idx;
            if (err > 63) err = 63;
            if (err < -64) err = -64;
            acc = longint'(err_accum) + err;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            err_accum = int'(acc);
            dterm = (prev_err - err) / 20;
            sum = longint'(err) * kp + longint'(dterm) * kd + longint'(err_accum) * ki;
            lim = longint'(servo_lim) * 256;
            in_lim = (sum > -lim) && (sum < lim);
            if (in_lim) begin
                cmd = longint'(ctr_servo) + sum / 256;
                if (cmd < 0) cmd = 0;
                if (cmd > 255) cmd = 255;
                servo_hold = int'(cmd);
            end
            prev_err = err;
            beat.line_error = 7'(err);
            beat.servo_cmd  = 8'(servo_hold);
            beat.in_range   = in_lim;
            steer_q.push_back(beat);
            clear_row();
        end
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic le);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{pixel_value: pix, line_end: le};
        do @(posedge aclk); while (!s_ready);
        track_pixel(int'(pix), le);
    endtask

    // Stop sending and wait out every pending result plus the pipeline tail.
    task automatic settle();
        s_valid <= 1'b0;
        while (steer_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_GAIN_P:       kp        = $signed(val);
            CFG_GAIN_D:       kd        = $signed(val);
            CFG_GAIN_I:       ki        = $signed(val);
            CFG_CENTER_INDEX: ctr_idx   = val[UCFG_W-1:0];
            CFG_SERVO_CENTER: ctr_servo = val[UCFG_W-1:0];
            CFG_SERVO_LIMIT:  servo_lim = val[UCFG_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3, 4, 5: return 16'($urandom_range(0, 1023)) - 16'd512;
            6, 7:    return 16'($urandom_range(0, 511));
            default: return 16'($urandom);
        endcase
    endfunction

    // 7-bit register value, sometimes with junk in the unused upper bits
    function automatic logic [CFG_DATA_W-1:0] pick_u7();
        logic [UCFG_W-1:0] v;
        case ($urandom_range(5))
            0:       v = '0;
            1:       v = '1;
            default: v = UCFG_W'($urandom_range(0, 127));
        endcase
        if ($urandom_range(3) == 0) return {9'($urandom), v};
        return {9'd0, v};
    endfunction

    task automatic randomize_regs();
        settle();
        write_reg(CFG_GAIN_P, pick_gain());
        write_reg(CFG_GAIN_D, pick_gain());
        write_reg(CFG_GAIN_I, pick_gain());
        write_reg(CFG_CENTER_INDEX, pick_u7());
        write_reg(CFG_SERVO_CENTER, pick_u7());
        write_reg(CFG_SERVO_LIMIT, pick_u7());
    endtask

    task automatic send_line(input int len, input bit mark_end, input shape_t shape);
        int               bg;
        int               band_lo;
        int               band_hi;
        int               lvl;
        logic [PIX_W-1:0] pix;
        bg      = $urandom_range(300, 1023);
        band_lo = $urandom_range(0, len - 1);
        band_hi = band_lo + $urandom_range(0, 20);
        lvl     = $urandom_range(0, 1023);
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_BAND:   pix = (i >= band_lo && i <= band_hi) ?
                                    PIX_W'($urandom_range(0, bg / 4)) :
                                    PIX_W'(bg - $urandom_range(0, 40));
                SHAPE_NOISE:  pix = PIX_W'($urandom_range(0, 1023));
                SHAPE_FLAT:   pix = PIX_W'(lvl);
                SHAPE_TOGGLE: pix = (i % 2) ? 10'd1023 : 10'd0;
                default:      pix = (i == len - 3) ? 10'd1023 : 10'd500;
            endcase
            push_pixel(pix, mark_end && (i == len - 1));
        end
    endtask

    task automatic test_short_lines();
        // one-pixel lines: no difference, both indices zero; then two-, six- and four-pixel lines
        push_pixel(10'd1023, 1'b1);
        push_pixel(10'd0, 1'b1);
        push_pixel(10'd0, 1'b0);
        push_pixel(10'd1023, 1'b1);
        push_pixel(10'd1023, 1'b0);
        push_pixel(10'd0, 1'b1);
        push_pixel(10'd1023, 1'b0);
        push_pixel(10'd1023, 1'b0);
        push_pixel(10'd0, 1'b0);
        push_pixel(10'd0, 1'b0);
        push_pixel(10'd1023, 1'b0);
        push_pixel(10'd1023, 1'b1);
        send_line(4, 1'b1, SHAPE_FLAT);
        settle();
    endtask

    task automatic test_long_lines();
        send_line(ROW_MAX, 1'b0, SHAPE_BAND);   // ends on the last index by itself
        send_line(ROW_MAX, 1'b1, SHAPE_NOISE);
        send_line(200, 1'b0, SHAPE_BAND);       // overrun spills into the next line
        send_line(3, 1'b1, SHAPE_FLAT);
        settle();
    endtask

    task automatic test_saturation();
        write_reg(CFG_SERVO_LIMIT, 16'd127);
        write_reg(CFG_CENTER_INDEX, 16'd0);
        write_reg(CFG_SERVO_CENTER, 16'd100);
        send_line(ROW_MAX, 1'b1, SHAPE_SPIKE);  // midpoint far right, error clips high
        settle();
        write_reg(CFG_CENTER_INDEX, 16'd127);
        send_line(4, 1'b1, SHAPE_FLAT);         // error clips low
        settle();
        // new center with a zero limit: held command must not move
        write_reg(CFG_SERVO_LIMIT, 16'd0);
        write_reg(CFG_SERVO_CENTER, 16'd0);
        send_line(4, 1'b1, SHAPE_FLAT);
        settle();
        write_reg(CFG_SERVO_LIMIT, 16'd127);
        send_line(4, 1'b1, SHAPE_FLAT);         // command goes below zero, clamps
        settle();
        write_reg(CFG_GAIN_P, 16'h8000);
        write_reg(CFG_GAIN_D, 16'h7fff);
        write_reg(CFG_GAIN_I, 16'h8000);
        write_reg(CFG_CENTER_INDEX, 16'd64);
        send_line(6, 1'b1, SHAPE_TOGGLE);
        send_line(5, 1'b1, SHAPE_BAND);
        settle();
        write_reg(CFG_SERVO_LIMIT, 16'd1);
        write_reg(CFG_GAIN_P, 16'd1);
        write_reg(CFG_GAIN_D, 16'd0);
        write_reg(CFG_GAIN_I, 16'd0);
        send_line(3, 1'b1, SHAPE_NOISE);
        settle();
    endtask

    task automatic test_random();
        int     phase_pixels;
        int     phase_lines;
        int     len;
        int     r;
        bit     mark_end;
        shape_t shape;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin snd_idle_pct = 11; rcv_idle_pct = 69; end
                1:       begin snd_idle_pct = 69; rcv_idle_pct = 11; end
                default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
            endcase
            phase_pixels = 0;
            phase_lines  = 0;
            while (phase_pixels < 100) begin
                if (phase_lines % 3 == 0) begin
                    // close any line left open before touching the registers
                    if (row_idx != 0) push_pixel(PIX_W'($urandom), 1'b1);
                    randomize_regs();
                end
                r = $urandom_range(99);
                if (r < 8) len = 1;
                else if (r < 60) len = $urandom_range(2, 24);
                else if (r < 85) len = $urandom_range(25, ROW_MAX - 1);
                else if (r < 95) len = ROW_MAX;
                else len = $urandom_range(ROW_MAX + 1, 160);
                if (len < ROW_MAX) mark_end = ($urandom_range(9) != 0);
                else if (len == ROW_MAX) mark_end = $urandom_range(1);
                else mark_end = 1'b0;
                r = $urandom_range(9);
                if (r < 5) shape = SHAPE_BAND;
                else if (r < 7) shape = SHAPE_NOISE;
                else if (r == 7) shape = SHAPE_FLAT;
                else if (r == 8) shape = SHAPE_TOGGLE;
                else shape = SHAPE_SPIKE;
                send_line(len, mark_end, shape);
                phase_pixels += len;
                phase_lines++;
            end
            if (row_idx != 0) push_pixel(PIX_W'($urandom), 1'b1);
            settle();
        end
    endtask

    initial begin
        reset_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_short_lines();
        test_long_lines();
        test_saturation();
        test_random();
        settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
